>>> rtl/core/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants of the RGB alpha compositor
// Holds the field widths, the command and register codes, the pixel type and
// the exact truncating division by 255 that every blend uses.
// ----------------------------------------------------------------------------
package rac_pkg;

	// Fixed field widths.
	localparam int CH_W      = 8;
	localparam int PROD_W    = 2 * CH_W;
	localparam int ADDR_W    = 26;
	localparam int WIDTH_W   = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;

	// Colour channel positions inside a pixel.
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	// Full and zero opacity.
	localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;
	localparam logic [CH_W-1:0] ALPHA_NONE = 8'h00;

	// Reset value of the screen width register.
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd320;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [2:0] rgb_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Compositing commands.
	typedef enum logic [1:0] {
		CMD_SPRITE = 2'd0,
		CMD_GLYPH  = 2'd1,
		CMD_FILL   = 2'd2,
		CMD_BLEND  = 2'd3
	} cmd_t;

	// Configuration register indices.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_IMAGE_ALPHA  = 3'd1,
		REG_FILL_RED     = 3'd2,
		REG_FILL_GREEN   = 3'd3,
		REG_FILL_BLUE    = 3'd4,
		REG_FILL_ALPHA   = 3'd5
	} cfg_reg_t;

	// Truncating x/255 for x up to 255*255. The estimate (x + x/256)/256 is
	// never more than one below the true quotient, so a single remainder
	// check corrects it.
	function automatic chan_t div255(input prod_t x);
		logic [PROD_W:0] sum;
		prod_t           q0;
		prod_t           rem;
		sum = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]};
		q0  = {{(CH_W-1){1'b0}}, sum[PROD_W:CH_W]};
		rem = x - ((q0 << CH_W) - q0);
		if (rem >= prod_t'(ALPHA_FULL)) begin
			q0 = q0 + prod_t'(1);
		end
		return q0[CH_W-1:0];
	endfunction

endpackage

>>> rtl/core/rgb_alpha_compositor_unit.sv
// ----------------------------------------------------------------------------
// rgb_alpha_compositor_unit: four-stage per-pixel compositor
// Blends a source texel, glyph coverage or fill colour onto a destination
// pixel and returns the framebuffer byte address and new colour.
// ----------------------------------------------------------------------------
// The unit takes one pixel word per clock while the output is not stalled
// and returns one result word per pixel, in order. The four register stages
// hold the alpha and row products, the alpha division and address sum, the
// channel products and address times three, then the final divisions by 255
// into the output register. The whole pipeline holds while a finished result
// is stalled. Configuration words are always taken and must only be written
// while the pipeline is empty.
module rgb_alpha_compositor_unit
	import rac_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	// Pixel input channel.
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [1:0]            cmd,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [CH_W-1:0]       src_red,
	input  logic [CH_W-1:0]       src_green,
	input  logic [CH_W-1:0]       src_blue,
	input  logic [CH_W-1:0]       src_alpha,
	input  logic [CH_W-1:0]       dst_red,
	input  logic [CH_W-1:0]       dst_green,
	input  logic [CH_W-1:0]       dst_blue,
	// Result output channel.
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  write_enable,
	output logic [ADDR_W-1:0]     byte_address,
	output logic [CH_W-1:0]       out_red,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_blue
);

	// Configuration registers.
	logic [WIDTH_W-1:0] screen_width_q;
	chan_t              image_alpha_q;
	rgb_t               fill_q;
	chan_t              fill_alpha_q;

	// Pipeline enable.
	logic advance;

	// Stage 1 registers.
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] px_s1;
	prod_t             alpha_prod_s1;
	logic [ADDR_W-1:0] row_base_s1;
	rgb_t              src_s1;
	rgb_t              dst_s1;

	// Stage 2 registers.
	logic              valid_s2;
	cmd_t              cmd_s2;
	chan_t             alpha_s2;
	logic [ADDR_W-1:0] pixel_idx_s2;
	rgb_t              src_s2;
	rgb_t              dst_s2;

	// Stage 3 registers.
	logic              valid_s3;
	cmd_t              cmd_s3;
	logic              full_s3;
	logic              zero_s3;
	logic [ADDR_W-1:0] addr_s3;
	prod_t [2:0]       prod_src_s3;
	prod_t [2:0]       prod_dst_s3;
	rgb_t              src_s3;
	rgb_t              dst_s3;

	// Stage 4 (output) registers.
	logic              valid_s4;
	logic              we_s4;
	logic [ADDR_W-1:0] addr_s4;
	rgb_t              rgb_s4;

	// Combinational stage logic.
	chan_t       alpha_factor;
	chan_t       alpha_div;
	chan_t       alpha_sel;
	rgb_t        src_in;
	rgb_t        dst_in;
	rgb_t        blend_src;
	chan_t       alpha_inv;
	rgb_t        rgb_next;
	logic        we_next;

	// Configuration words are always accepted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q   <= WIDTH_RESET;
			image_alpha_q    <= ALPHA_FULL;
			fill_q[CH_RED]   <= ALPHA_FULL;
			fill_q[CH_GREEN] <= ALPHA_FULL;
			fill_q[CH_BLUE]  <= ALPHA_FULL;
			fill_alpha_q     <= ALPHA_FULL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q   <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_ALPHA:  image_alpha_q    <= cfg_data[CH_W-1:0];
				REG_FILL_RED:     fill_q[CH_RED]   <= cfg_data[CH_W-1:0];
				REG_FILL_GREEN:   fill_q[CH_GREEN] <= cfg_data[CH_W-1:0];
				REG_FILL_BLUE:    fill_q[CH_BLUE]  <= cfg_data[CH_W-1:0];
				REG_FILL_ALPHA:   fill_alpha_q     <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished result is held.
	assign advance   = !(valid_s4 && res_stall);
	assign pix_stall = !advance;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: alpha product and row base address.
	assign src_in       = {src_red, src_green, src_blue};
	assign dst_in       = {dst_red, dst_green, dst_blue};
	assign alpha_factor = (cmd_t'(cmd) == CMD_SPRITE) ? image_alpha_q : fill_alpha_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1        <= cmd_t'(cmd);
			px_s1         <= ADDR_W'(pos_x);
			alpha_prod_s1 <= prod_t'(src_alpha) * prod_t'(alpha_factor);
			row_base_s1   <= ADDR_W'(pos_y) * ADDR_W'(screen_width_q);
			src_s1        <= src_in;
			dst_s1        <= dst_in;
		end
	end

	// Stage 2: effective alpha and pixel index.
	assign alpha_div = div255(alpha_prod_s1);

	always_comb begin
		case (cmd_s1)
			CMD_SPRITE, CMD_GLYPH: alpha_sel = alpha_div;
			default:               alpha_sel = fill_alpha_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2       <= cmd_s1;
			alpha_s2     <= alpha_sel;
			pixel_idx_s2 <= row_base_s1 + px_s1;
			src_s2       <= src_s1;
			dst_s2       <= dst_s1;
		end
	end

	// Stage 3: per-channel products and byte address.
	assign blend_src = (cmd_s2 == CMD_SPRITE) ? src_s2 : fill_q;
	assign alpha_inv = ALPHA_FULL - alpha_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s3  <= cmd_s2;
			full_s3 <= (alpha_s2 == ALPHA_FULL);
			zero_s3 <= (alpha_s2 == ALPHA_NONE);
			addr_s3 <= (pixel_idx_s2 << 1) + pixel_idx_s2;
			src_s3  <= src_s2;
			dst_s3  <= dst_s2;
			for (int ch = 0; ch < 3; ch++) begin
				prod_src_s3[ch] <= prod_t'(alpha_s2) * prod_t'(blend_src[ch]);
				prod_dst_s3[ch] <= prod_t'(dst_s2[ch]) * prod_t'(alpha_inv);
			end
		end
	end

	// Stage 4: final divisions and mode selection.
	always_comb begin
		we_next  = 1'b1;
		rgb_next = dst_s3;
		case (cmd_s3)
			CMD_SPRITE: begin
				if (full_s3) begin
					rgb_next = src_s3;
				end else begin
					for (int ch = 0; ch < 3; ch++) begin
						rgb_next[ch] = div255(prod_src_s3[ch]) + div255(prod_dst_s3[ch]);
					end
				end
			end
			CMD_GLYPH: begin
				if (zero_s3) begin
					we_next = 1'b0;
				end else begin
					for (int ch = 0; ch < 3; ch++) begin
						rgb_next[ch] = div255(prod_src_s3[ch] + prod_dst_s3[ch]);
					end
				end
			end
			CMD_FILL: begin
				rgb_next = fill_q;
			end
			default: begin
				for (int ch = 0; ch < 3; ch++) begin
					rgb_next[ch] = div255(prod_src_s3[ch]) + div255(prod_dst_s3[ch]);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			we_s4   <= we_next;
			addr_s4 <= addr_s3;
			rgb_s4  <= rgb_next;
		end
	end

	// Result word.
	assign res_valid    = valid_s4;
	assign write_enable = we_s4;
	assign byte_address = addr_s4;
	assign out_red      = rgb_s4[CH_RED];
	assign out_green    = rgb_s4[CH_GREEN];
	assign out_blue     = rgb_s4[CH_BLUE];

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgb_alpha_compositor_unit
// Pixel words go in from a queue through a clocked driver, and result words
// are checked by a clocked monitor against a predictor of the four blend
// modes. The run steps through several register settings and idle patterns,
// and it includes one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
	import rac_pkg::*;

	localparam int COORD_W     = 12;
	localparam int FULL        = 255;
	localparam int LATENCY     = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		cmd_t               cmd;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		chan_t              src_red;
		chan_t              src_green;
		chan_t              src_blue;
		chan_t              src_alpha;
		chan_t              dst_red;
		chan_t              dst_green;
		chan_t              dst_blue;
	} pixel_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] byte_address;
		chan_t             out_red;
		chan_t             out_green;
		chan_t             out_blue;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	logic   pix_valid = 1'b0;
	logic   pix_stall;
	pixel_t offer = '0;

	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        write_enable;
	logic [ADDR_W-1:0] byte_address;
	chan_t       out_red;
	chan_t       out_green;
	chan_t       out_blue;

	// Copy of the register file, kept in step with every configuration write.
	logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
	chan_t img_alpha  = 8'd255;
	chan_t fill_red   = 8'd255;
	chan_t fill_green = 8'd255;
	chan_t fill_blue  = 8'd255;
	chan_t fill_alpha = 8'd255;

	pixel_t  pixel_queue[$];
	result_t expected_pixels[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	rgb_alpha_compositor_unit #(
		.COORD_BITS(COORD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.cmd(offer.cmd),
		.pos_x(offer.pos_x),
		.pos_y(offer.pos_y),
		.src_red(offer.src_red),
		.src_green(offer.src_green),
		.src_blue(offer.src_blue),
		.src_alpha(offer.src_alpha),
		.dst_red(offer.dst_red),
		.dst_green(offer.dst_green),
		.dst_blue(offer.dst_blue),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.write_enable(write_enable),
		.byte_address(byte_address),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue)
	);

	always #5 clk = ~clk;

	// Blend with two separately truncated terms.
	function automatic chan_t mix_split(int a, int s, int d);
		return chan_t'((a * s) / FULL + (d * (FULL - a)) / FULL);
	endfunction

	// Blend with a single truncating division.
	function automatic chan_t mix_joint(int a, int s, int d);
		return chan_t'((a * s + d * (FULL - a)) / FULL);
	endfunction

	// Works out the result word for one pixel word under the current registers.
	function automatic result_t blend_pixel(pixel_t p);
		result_t         res;
		int              a;
		longint unsigned addr_full;
		res.write_enable = 1'b1;
		addr_full = p.pos_y;
		addr_full = 3 * (addr_full * width_reg + p.pos_x);
		res.byte_address = addr_full[ADDR_W-1:0];
		case (p.cmd)
			CMD_SPRITE: begin
				a = int'(p.src_alpha) * int'(img_alpha) / FULL;
				if (a == FULL) begin
					res.out_red   = p.src_red;
					res.out_green = p.src_green;
					res.out_blue  = p.src_blue;
				end else begin
					res.out_red   = mix_split(a, p.src_red, p.dst_red);
					res.out_green = mix_split(a, p.src_green, p.dst_green);
					res.out_blue  = mix_split(a, p.src_blue, p.dst_blue);
				end
			end
			CMD_GLYPH: begin
				a = int'(p.src_alpha) * int'(fill_alpha) / FULL;
				if (a == 0) begin
					res.write_enable = 1'b0;
					res.out_red   = p.dst_red;
					res.out_green = p.dst_green;
					res.out_blue  = p.dst_blue;
				end else begin
					res.out_red   = mix_joint(a, fill_red, p.dst_red);
					res.out_green = mix_joint(a, fill_green, p.dst_green);
					res.out_blue  = mix_joint(a, fill_blue, p.dst_blue);
				end
			end
			CMD_FILL: begin
				res.out_red   = fill_red;
				res.out_green = fill_green;
				res.out_blue  = fill_blue;
			end
			default: begin
				res.out_red   = mix_split(fill_alpha, fill_red, p.dst_red);
				res.out_green = mix_split(fill_alpha, fill_green, p.dst_green);
				res.out_blue  = mix_split(fill_alpha, fill_blue, p.dst_blue);
			end
		endcase
		return res;
	endfunction

	function automatic pixel_t make_pixel(cmd_t c, int x, int y, int sr, int sg, int sb,
			int sa, int dr, int dg, int db);
		pixel_t p;
		p.cmd = c;
		p.pos_x = COORD_W'(x);
		p.pos_y = COORD_W'(y);
		p.src_red = chan_t'(sr);
		p.src_green = chan_t'(sg);
		p.src_blue = chan_t'(sb);
		p.src_alpha = chan_t'(sa);
		p.dst_red = chan_t'(dr);
		p.dst_green = chan_t'(dg);
		p.dst_blue = chan_t'(db);
		return p;
	endfunction

	// Random pixel word, leaning towards edge coordinates and the alpha extremes.
	function automatic pixel_t random_pixel();
		pixel_t p;
		p = pixel_t'({$urandom, $urandom, $urandom});
		p.cmd = cmd_t'($urandom_range(3));
		case ($urandom_range(7))
			0: p.src_alpha = 8'd0;
			1: p.src_alpha = 8'd255;
			default: ;
		endcase
		case ($urandom_range(7))
			0: p.pos_x = '0;
			1: p.pos_x = '1;
			2: p.pos_y = '0;
			3: p.pos_y = '1;
			default: ;
		endcase
		return p;
	endfunction

	// Driver: offers the next pixel word once the current one has been taken.
	always @(posedge clk) begin : drive
		logic send;
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				expected_pixels.push_back(blend_pixel(offer));
			end
			if (!pix_valid || !pix_stall) begin
				send = pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (send) begin
					offer <= pixel_queue.pop_front();
				end
				pix_valid <= send;
			end
		end
	end

	// Receiver stall, with a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	// Monitor: each result word taken is checked against the oldest prediction.
	always @(posedge clk) begin : check
		result_t got;
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {write_enable, byte_address, out_red, out_green, out_blue};
			if (expected_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result word: we=%0d addr=%0h rgb=%02h%02h%02h",
						got.write_enable, got.byte_address,
						got.out_red, got.out_green, got.out_blue);
				end
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: expected we=%0d addr=%0h rgb=%02h%02h%02h, got we=%0d addr=%0h rgb=%02h%02h%02h",
							want.write_enable, want.byte_address,
							want.out_red, want.out_green, want.out_blue,
							got.write_enable, got.byte_address,
							got.out_red, got.out_green, got.out_blue);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCREEN_WIDTH: width_reg = data;
			REG_IMAGE_ALPHA:  img_alpha = data[CH_W-1:0];
			REG_FILL_RED:     fill_red = data[CH_W-1:0];
			REG_FILL_GREEN:   fill_green = data[CH_W-1:0];
			REG_FILL_BLUE:    fill_blue = data[CH_W-1:0];
			default:          fill_alpha = data[CH_W-1:0];
		endcase
	endtask

	// Waits until every word has gone in and every result has come back.
	task automatic wait_idle();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || pix_valid || expected_pixels.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// Colour register value: mostly random, sometimes fully opaque, upper bits noise.
	function automatic logic [CFG_DAT_W-1:0] random_colour();
		logic [CFG_DAT_W-1:0] v;
		v = CFG_DAT_W'($urandom);
		if ($urandom_range(3) == 0) begin
			v[CH_W-1:0] = 8'd255;
		end
		return v;
	endfunction

	initial begin
		logic [CFG_DAT_W-1:0] w;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: texel copy, zero and partial alpha, every mode.
		set_idle(0, 0);
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 0, 0, 12, 34, 56, 255, 200, 100, 50));
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 1, 0, 12, 34, 56, 0, 200, 100, 50));
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 4095, 4095, 255, 255, 255, 254, 0, 0, 0));
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 319, 0, 255, 0, 255, 128, 0, 255, 0));
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 5, 7, 0, 0, 0, 255, 255, 255, 255));
		pixel_queue.push_back(make_pixel(CMD_GLYPH, 3, 9, 0, 0, 0, 0, 17, 34, 51));
		pixel_queue.push_back(make_pixel(CMD_GLYPH, 4095, 0, 0, 0, 0, 255, 0, 0, 0));
		pixel_queue.push_back(make_pixel(CMD_GLYPH, 0, 4095, 0, 0, 0, 1, 255, 128, 0));
		pixel_queue.push_back(make_pixel(CMD_FILL, 100, 200, 0, 0, 0, 0, 1, 2, 3));
		pixel_queue.push_back(make_pixel(CMD_BLEND, 2048, 2048, 0, 0, 0, 0, 0, 128, 255));
		wait_idle();

		// Low extremes of every register.
		write_reg(REG_SCREEN_WIDTH, 13'd1);
		write_reg(REG_IMAGE_ALPHA, 13'd0);
		write_reg(REG_FILL_RED, 13'd0);
		write_reg(REG_FILL_GREEN, 13'd0);
		write_reg(REG_FILL_BLUE, 13'd0);
		write_reg(REG_FILL_ALPHA, 13'd0);
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 4095, 4095, 9, 9, 9, 255, 90, 80, 70));
		pixel_queue.push_back(make_pixel(CMD_GLYPH, 0, 4095, 0, 0, 0, 255, 90, 80, 70));
		pixel_queue.push_back(make_pixel(CMD_FILL, 4095, 0, 0, 0, 0, 0, 90, 80, 70));
		pixel_queue.push_back(make_pixel(CMD_BLEND, 1, 1, 0, 0, 0, 0, 255, 255, 255));
		wait_idle();

		// Widths out of range: the largest the register holds, then zero.
		write_reg(REG_SCREEN_WIDTH, 13'h1FFF);
		write_reg(REG_IMAGE_ALPHA, 13'h1FFF);
		pixel_queue.push_back(make_pixel(CMD_SPRITE, 4095, 4095, 1, 2, 3, 200, 4, 5, 6));
		pixel_queue.push_back(make_pixel(CMD_FILL, 4095, 2048, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();
		write_reg(REG_SCREEN_WIDTH, 13'd0);
		pixel_queue.push_back(make_pixel(CMD_BLEND, 4095, 4095, 0, 0, 0, 0, 7, 8, 9));
		pixel_queue.push_back(make_pixel(CMD_GLYPH, 17, 4095, 0, 0, 0, 99, 7, 8, 9));
		wait_idle();

		// Output held off for a long stretch while pixels keep arriving.
		write_reg(REG_SCREEN_WIDTH, 13'd4096);
		write_reg(REG_IMAGE_ALPHA, 13'd255);
		write_reg(REG_FILL_RED, 13'd255);
		write_reg(REG_FILL_GREEN, 13'd255);
		write_reg(REG_FILL_BLUE, 13'd255);
		write_reg(REG_FILL_ALPHA, 13'd255);
		set_idle(0, 0);
		hold_req <= hold_req + 1;
		repeat (200) pixel_queue.push_back(random_pixel());
		wait_idle();

		// Random phases, each under new settings and one of four idle patterns.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase % 4)
				0: set_idle(0, 0);
				1: set_idle(87, 0);
				2: set_idle(0, 87);
				default: set_idle(6, 6);
			endcase
			if (phase == 5) begin
				w = CFG_DAT_W'($urandom);
			end else begin
				w = CFG_DAT_W'($urandom_range(4096, 1));
			end
			write_reg(REG_SCREEN_WIDTH, w);
			write_reg(REG_IMAGE_ALPHA, random_colour());
			write_reg(REG_FILL_RED, random_colour());
			write_reg(REG_FILL_GREEN, random_colour());
			write_reg(REG_FILL_BLUE, random_colour());
			write_reg(REG_FILL_ALPHA, random_colour());
			repeat (190) pixel_queue.push_back(random_pixel());
			wait_idle();
		end

		if (fail_count == 0 && expected_pixels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/rac_pkg.sv
rtl/core/rgb_alpha_compositor_unit.sv
test/testbench.sv
